### design/ttv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttv_pkg
// Types and constants shared by the triangle tangent vector block.
// ----------------------------------------------------------------------------
package ttv_pkg;

  localparam int unsigned CoordWidth = 32;
  localparam int unsigned OutOne     = 16384;
  localparam int unsigned NormBits   = 30;

  typedef struct packed {
    logic signed [CoordWidth-1:0] pos_x;
    logic signed [CoordWidth-1:0] pos_y;
    logic signed [CoordWidth-1:0] pos_z;
    logic signed [CoordWidth-1:0] tex_u;
    logic signed [CoordWidth-1:0] tex_v;
  } vertex_t;

  typedef struct packed {
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_z;
    logic               degenerate;
  } tangent_t;

endpackage

### design/ttv_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttv_front
// Collects three vertices, forms edges and texture deltas, and pushes one
// triangle request into the queue.
// ----------------------------------------------------------------------------
module ttv_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  output logic                                full_o,
  input  ttv_pkg::vertex_t                    vtx_i,
  output logic                                tri_valid_o,
  input  logic                                tri_ready_i,
  output logic signed [ttv_pkg::CoordWidth:0] e1_o [3],
  output logic signed [ttv_pkg::CoordWidth:0] e2_o [3],
  output logic signed [ttv_pkg::CoordWidth:0] d_o  [4]
);
  localparam int unsigned CW = ttv_pkg::CoordWidth;

  logic signed [CW-1:0] a_q [5], b_q [5], c [5];
  logic [1:0] cnt_q;
  logic       vld_q;

  assign c[0] = vtx_i.pos_x[CW-1:0];
  assign c[1] = vtx_i.pos_y[CW-1:0];
  assign c[2] = vtx_i.pos_z[CW-1:0];
  assign c[3] = vtx_i.tex_u[CW-1:0];
  assign c[4] = vtx_i.tex_v[CW-1:0];

  // third vertex needs a free slot
  assign full_o      = vld_q && (cnt_q == 2'd2) && !tri_ready_i;
  assign tri_valid_o = vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      vld_q <= 1'b0;
      a_q   <= '{default: '0};
      b_q   <= '{default: '0};
      e1_o  <= '{default: '0};
      e2_o  <= '{default: '0};
      d_o   <= '{default: '0};
    end else begin
      if (tri_ready_i) vld_q <= 1'b0;
      if (push_i && !full_o) begin
        if (cnt_q == 2'd1) begin
          b_q   <= c;
          cnt_q <= 2'd2;
        end else if (cnt_q == 2'd2) begin
          for (int k = 0; k < 3; k++) begin
            e1_o[k] <= {b_q[k][CW-1], b_q[k]} - {a_q[k][CW-1], a_q[k]};
            e2_o[k] <= {c[k][CW-1], c[k]} - {a_q[k][CW-1], a_q[k]};
          end
          d_o[0] <= {b_q[3][CW-1], b_q[3]} - {a_q[3][CW-1], a_q[3]};
          d_o[1] <= {b_q[4][CW-1], b_q[4]} - {a_q[4][CW-1], a_q[4]};
          d_o[2] <= {c[3][CW-1], c[3]} - {a_q[3][CW-1], a_q[3]};
          d_o[3] <= {c[4][CW-1], c[4]} - {a_q[4][CW-1], a_q[4]};
          vld_q <= 1'b1;
          cnt_q <= 2'd0;
        end else begin
          a_q   <= c;
          cnt_q <= 2'd1;
        end
      end
    end
  end
endmodule

### design/ttv_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttv_back
// Sequencer: products, determinant sign, shared normalize shift, bitwise
// square root and restoring divisions, one result register.
// ----------------------------------------------------------------------------
module ttv_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                tri_valid_i,
  output logic                                tri_ready_o,
  input  logic signed [ttv_pkg::CoordWidth:0] e1_i [3],
  input  logic signed [ttv_pkg::CoordWidth:0] e2_i [3],
  input  logic signed [ttv_pkg::CoordWidth:0] d_i  [4],
  output logic                                empty_o,
  input  logic                                pop_i,
  output ttv_pkg::tangent_t                   res_o
);
  localparam int unsigned CW = ttv_pkg::CoordWidth;
  localparam int unsigned PW = 2*CW+3;
  localparam int unsigned SW = $clog2(PW+1);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_DET, S_SCAN, S_SHIFT, S_SQ, S_SQRT, S_DIV, S_OUT
  } state_e;

  state_e state_q;
  logic signed [CW:0] e1_q [3], e2_q [3], d_q [4];
  logic signed [PW-1:0] pa_q, pb_q, t_q [3];
  logic [PW-1:0] mag_q [3];
  logic          neg_q [3];
  logic          flip_q;
  logic [1:0]    k_q;
  logic [SW-1:0] sh_q;
  logic [63:0]   sm_q [3];
  logic [63:0]   sum_q, rem_q, res_q, one_q;
  logic [31:0]   len_q;
  logic [48:0]   num_q, qd_q;
  logic [5:0]    bit_q;
  logic [14:0]   qo_q;
  logic          full_q;
  ttv_pkg::tangent_t out_q;
  logic [PW-1:0] orm;
  logic [31:0]   smk;
  logic [63:0]   sq;
  logic [50:0]   rr;
  logic          qbit;

  assign tri_ready_o = (state_q == S_IDLE) && !full_q;
  assign empty_o     = !full_q;
  assign res_o       = out_q;
  assign orm  = mag_q[0] | mag_q[1] | mag_q[2];
  assign smk  = sm_q[k_q][31:0];
  assign sq   = 64'(smk) * 64'(smk);
  assign rr   = {1'b0, qd_q, num_q[48]};
  assign qbit = (rr >= {18'd0, len_q, 1'b0});

  function automatic logic [15:0] apply(input logic [14:0] q, input logic n);
    logic [15:0] v;
    v = {1'b0, q};
    return n ? 16'(-v) : v;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      full_q  <= 1'b0;
    end else begin
      if (pop_i && full_q) full_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (tri_valid_i && !full_q) begin
          e1_q <= e1_i; e2_q <= e2_i; d_q <= d_i;
          pa_q <= PW'(d_i[0]) * PW'(d_i[3]);
          pb_q <= PW'(d_i[2]) * PW'(d_i[1]);
          k_q  <= 2'd0;
          state_q <= S_DET;
        end
        S_DET: begin
          out_q <= '{tangent_x: '0, tangent_y: '0, tangent_z: '0, degenerate: 1'b1};
          if (pa_q == pb_q) begin
            full_q <= 1'b1; state_q <= S_IDLE;
          end else begin
            flip_q <= pa_q < pb_q;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          t_q[k_q] <= PW'(d_q[3]) * PW'(e1_q[k_q]) - PW'(d_q[1]) * PW'(e2_q[k_q]);
          if (k_q == 2'd2) begin k_q <= 2'd0; state_q <= S_SCAN; end
          else k_q <= k_q + 2'd1;
        end
        S_SCAN: begin
          for (int k = 0; k < 3; k++) begin
            neg_q[k] <= t_q[k][PW-1] ^ flip_q;
            mag_q[k] <= t_q[k][PW-1] ? PW'(-t_q[k]) : PW'(t_q[k]);
          end
          sh_q <= '0;
          state_q <= S_SHIFT;
        end
        S_SHIFT: begin
          if (orm == '0) begin
            full_q <= 1'b1; state_q <= S_IDLE;
          end else if ((orm >> (sh_q + SW'(ttv_pkg::NormBits))) != '0) begin
            sh_q <= sh_q + SW'(1);
          end else begin
            for (int k = 0; k < 3; k++) sm_q[k] <= 64'(mag_q[k] >> sh_q);
            sum_q <= '0; k_q <= 2'd0;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          sum_q <= sum_q + sq;
          if (k_q == 2'd2) begin
            k_q <= 2'd0; rem_q <= sum_q + sq; res_q <= '0;
            one_q <= 64'd1 << 62;
            state_q <= S_SQRT;
          end else k_q <= k_q + 2'd1;
        end
        S_SQRT: begin
          if (one_q == '0) begin
            len_q <= res_q[31:0];
            num_q <= {sm_q[0][33:0], 15'd0} + 49'(res_q[31:0]);
            qd_q <= '0; bit_q <= '0;
            state_q <= S_DIV;
          end else if (one_q > rem_q && res_q == '0) begin
            one_q <= one_q >> 2;
          end else begin
            if (rem_q >= res_q + one_q) begin
              rem_q <= rem_q - (res_q + one_q);
              res_q <= (res_q >> 1) + one_q;
            end else res_q <= res_q >> 1;
            one_q <= one_q >> 2;
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle
          if (qbit) qd_q <= 49'(rr - {18'd0, len_q, 1'b0});
          else qd_q <= rr[48:0];
          num_q <= {num_q[47:0], qbit};
          if (bit_q == 6'd48) begin
            qo_q <= (({num_q[47:0], qbit} > 49'(ttv_pkg::OutOne))
                    ? 15'(ttv_pkg::OutOne) : {num_q[13:0], qbit});
            state_q <= S_OUT;
          end else bit_q <= bit_q + 6'd1;
        end
        S_OUT: begin
          unique case (k_q)
            2'd0: out_q.tangent_x <= apply(qo_q, neg_q[0]);
            2'd1: out_q.tangent_y <= apply(qo_q, neg_q[1]);
            default: out_q.tangent_z <= apply(qo_q, neg_q[2]);
          endcase
          if (k_q == 2'd2) begin
            out_q.degenerate <= 1'b0; full_q <= 1'b1; state_q <= S_IDLE;
          end else begin
            k_q <= k_q + 2'd1;
            num_q <= {sm_q[k_q+2'd1][33:0], 15'd0} + 49'(len_q);
            qd_q <= '0; bit_q <= '0; state_q <= S_DIV;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

### design/triangle_tangent_vector.sv
`timescale 1ns / 1ps
// With the back end idle, the result follows the third vertex through the
// front register, the shift search, the square root and three divide and
// write passes; a zero determinant or a zero vector ends the pass early.
// Throughput: first two vertices at one per cycle; the third stalls while a
// triangle waits between front and back; one triangle per back-end pass.
// Reset: asynchronous active low; clears vertex count, held vertices, queue.
// ----------------------------------------------------------------------------
// triangle_tangent_vector
// Per-triangle unit tangent from three textured vertices, signed Q1.14.
// ----------------------------------------------------------------------------
module triangle_tangent_vector (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  ttv_pkg::vertex_t  vtx_i,
  output logic              empty,
  input  logic              pop,
  output ttv_pkg::tangent_t res_o
);
  logic tri_valid, tri_ready;
  logic signed [ttv_pkg::CoordWidth:0] e1 [3], e2 [3], d [4];

  ttv_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .vtx_i,
    .tri_valid_o(tri_valid), .tri_ready_i(tri_ready),
    .e1_o(e1), .e2_o(e2), .d_o(d)
  );

  ttv_back u_back (
    .clk_i, .rst_ni, .tri_valid_i(tri_valid), .tri_ready_o(tri_ready),
    .e1_i(e1), .e2_i(e2), .d_i(d), .empty_o(empty), .pop_i(pop), .res_o
  );
endmodule

### design/ttv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttv_checker
// Port-level checks on the result side.
// ----------------------------------------------------------------------------
module ttv_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              empty,
  input logic              pop,
  input ttv_pkg::tangent_t res_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(res_o)) else $error("result dropped");
  a_deg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && res_o.degenerate |-> res_o.tangent_x == 16'd0 && res_o.tangent_y == 16'd0
      && res_o.tangent_z == 16'd0) else $error("degenerate nonzero");
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && pop |=> empty) else $error("result repeated");
endmodule

bind triangle_tangent_vector ttv_checker u_chk (.*);

### dv/triangle_tangent_vector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_tangent_vector_tb
// Streams textured vertices into the tangent block, three to a triangle, and
// checks every tangent against a cycle-free predictor or a typed row. A
// directed table covers axis cases, a flipped determinant, degenerate
// triangles and coordinate extremes. Random triangles follow under several
// idle and stall mixes, including a long receiver hold-off that fills the block.
// ----------------------------------------------------------------------------
module triangle_tangent_vector_tb;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned DrainCycles   = 300;
  localparam int unsigned HoldCycles    = 600;
  localparam logic [31:0] QOne          = 32'h0001_0000;

  typedef struct {
    ttv_pkg::vertex_t  vtx;
    bit                typed;
    ttv_pkg::tangent_t want;
  } stim_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              push;
  logic              full;
  ttv_pkg::vertex_t  vtx;
  logic              empty;
  logic              pop;
  ttv_pkg::tangent_t res;

  ttv_pkg::tangent_t tangent_q[$];
  int       mismatch_cnt;
  int       idle_cnt;
  int       send_idle_pct;
  int       recv_stall_pct;
  int       hold_seq;

  // Predictor state: the two held corners, sign-extended.
  logic signed [127:0] corner_a[5];
  logic signed [127:0] corner_b[5];
  int                  corner_cnt;

  triangle_tangent_vector u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push  (push),
    .full  (full),
    .vtx_i (vtx),
    .empty (empty),
    .pop   (pop),
    .res_o (res)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic ttv_pkg::tangent_t tangent_of(input ttv_pkg::vertex_t v,
                                                   output bit valid);
    logic signed [127:0] c[5];
    logic signed [127:0] e1[3];
    logic signed [127:0] e2[3];
    logic signed [127:0] du1, dv1, du2, dv2, det;
    logic signed [127:0] t[3];
    logic [127:0]        mag[3];
    bit                  tneg[3];
    bit                  flip;
    logic [63:0]         sm[3];
    logic [63:0]         sum, len, one, x, q;
    int                  maxb, s;
    ttv_pkg::tangent_t   r;
    c[0] = v.pos_x;
    c[1] = v.pos_y;
    c[2] = v.pos_z;
    c[3] = v.tex_u;
    c[4] = v.tex_v;
    valid = 1'b0;
    r = '0;
    if (corner_cnt == 1) begin
      corner_b = c;
      corner_cnt = 2;
      return r;
    end
    if (corner_cnt != 2) begin
      corner_a = c;
      corner_cnt = 1;
      return r;
    end
    corner_cnt = 0;
    valid = 1'b1;
    r.degenerate = 1'b1;
    for (int k = 0; k < 3; k++) begin
      e1[k] = corner_b[k] - corner_a[k];
      e2[k] = c[k] - corner_a[k];
    end
    du1 = corner_b[3] - corner_a[3];
    dv1 = corner_b[4] - corner_a[4];
    du2 = c[3] - corner_a[3];
    dv2 = c[4] - corner_a[4];
    det = du1 * dv2 - du2 * dv1;
    if (det == 0) return r;
    flip = det < 0;
    maxb = 0;
    for (int k = 0; k < 3; k++) begin
      t[k] = dv2 * e1[k] - dv1 * e2[k];
      tneg[k] = (t[k] < 0) != flip;
      mag[k] = (t[k] < 0) ? -t[k] : t[k];
      for (int b = 0; b < 128; b++)
        if (mag[k][b] && b + 1 > maxb) maxb = b + 1;
    end
    if (maxb == 0) return r;
    s = (maxb > ttv_pkg::NormBits) ? maxb - ttv_pkg::NormBits : 0;
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      sm[k] = 64'(mag[k] >> s);
      sum += sm[k] * sm[k];
    end
    // Bitwise floor square root.
    x = sum;
    len = '0;
    one = 64'd1 << 62;
    while (one > x) one >>= 2;
    while (one != 0) begin
      if (x >= len + one) begin
        x -= len + one;
        len = (len >> 1) + one;
      end else begin
        len >>= 1;
      end
      one >>= 2;
    end
    if (len == 0) return r;
    for (int k = 0; k < 3; k++) begin
      q = (sm[k] * ttv_pkg::OutOne * 2 + len) / (2 * len);
      if (q > ttv_pkg::OutOne) q = ttv_pkg::OutOne;
      q = tneg[k] ? -q : q;
      case (k)
        0: r.tangent_x = q[15:0];
        1: r.tangent_y = q[15:0];
        default: r.tangent_z = q[15:0];
      endcase
    end
    r.degenerate = 1'b0;
    return r;
  endfunction

  // Offer one vertex and record its expected tangent at acceptance.
  task automatic send_vertex(input ttv_pkg::vertex_t v, input bit typed,
                             input ttv_pkg::tangent_t want);
    bit                valid;
    ttv_pkg::tangent_t pred;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    vtx  <= v;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    pred = tangent_of(v, valid);
    if (valid) tangent_q.insert(tangent_q.size(), typed ? want : pred);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return 32'h8000_0000;
      2:       return 32'h7fff_ffff;
      3:       return '0;
      default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    endcase
  endfunction

  function automatic ttv_pkg::vertex_t rand_vertex();
    ttv_pkg::vertex_t v;
    v.pos_x = rand_coord();
    v.pos_y = rand_coord();
    v.pos_z = rand_coord();
    v.tex_u = rand_coord();
    v.tex_v = rand_coord();
    return v;
  endfunction

  task automatic send_triangle();
    ttv_pkg::vertex_t v0;
    ttv_pkg::vertex_t v1;
    ttv_pkg::vertex_t v2;
    v0 = rand_vertex();
    v1 = rand_vertex();
    v2 = rand_vertex();
    case ($urandom_range(0, 9))
      0: begin  // repeat corner uv, zero det
        v2.tex_u = v1.tex_u; v2.tex_v = v1.tex_v;
      end
      1: begin  // all positions equal, zero tangent
        v1.pos_x = v0.pos_x; v1.pos_y = v0.pos_y; v1.pos_z = v0.pos_z;
        v2.pos_x = v0.pos_x; v2.pos_y = v0.pos_y; v2.pos_z = v0.pos_z;
      end
      default: ;
    endcase
    if ($urandom_range(0, 9) == 0) v2.tex_v = v1.tex_v;
    send_vertex(v0, 1'b0, '0);
    send_vertex(v1, 1'b0, '0);
    send_vertex(v2, 1'b0, '0);
  endtask

  // Result side: stall at random, or hold off for a requested stretch.
  initial begin
    int seen;
    int left;
    seen = 0;
    left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seq != seen) begin
        seen = hold_seq;
        left = HoldCycles;
      end
      if (left > 0) begin
        pop <= 1'b0;
        left--;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (tangent_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected tangent %p", res);
      end else begin
        if (res.tangent_x !== tangent_q[0].tangent_x ||
            res.tangent_y !== tangent_q[0].tangent_y ||
            res.tangent_z !== tangent_q[0].tangent_z ||
            res.degenerate !== tangent_q[0].degenerate) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("tangent mismatch: expected %p actual %p", tangent_q[0], res);
        end
        void'(tangent_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    int        sidle[4];
    int        rstall[4];
    sidle  = '{0, 75, 0, 26};
    rstall = '{0, 0, 75, 26};
    push = 1'b0;
    vtx = '0;
    rst_ni = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_seq = 0;
    corner_cnt = 0;
    foreach (corner_a[k]) begin
      corner_a[k] = '0;
      corner_b[k] = '0;
    end

    // Unit x tangent from axis-aligned uv.
    rows.insert(rows.size(), '{'{0, 0, 0, 0, 0}, 1'b0, '0});
    rows.insert(rows.size(), '{'{QOne, 0, 0, QOne, 0}, 1'b0, '0});
    rows.insert(rows.size(), '{'{0, QOne, 0, 0, QOne}, 1'b1, '{16'sd16384, 0, 0, 1'b0}});
    // Swapped uv: negative determinant flips the tangent to +y.
    rows.insert(rows.size(), '{'{0, 0, 0, 0, 0}, 1'b0, '0});
    rows.insert(rows.size(), '{'{QOne, 0, 0, 0, QOne}, 1'b0, '0});
    rows.insert(rows.size(), '{'{0, QOne, 0, QOne, 0}, 1'b1, '{0, 16'sd16384, 0, 1'b0}});
    // All-zero triangle: zero determinant.
    for (int i = 0; i < 3; i++)
      rows.insert(rows.size(), '{'{0, 0, 0, 0, 0}, i == 2, '{0, 0, 0, 1'b1}});
    // Coincident positions with a good uv frame: zero tangent.
    rows.insert(rows.size(), '{'{5, 5, 5, 0, 0}, 1'b0, '0});
    rows.insert(rows.size(), '{'{5, 5, 5, QOne, 0}, 1'b0, '0});
    rows.insert(rows.size(), '{'{5, 5, 5, 0, QOne}, 1'b1, '{0, 0, 0, 1'b1}});
    // Coordinate extremes, checked by the predictor.
    rows.insert(rows.size(), '{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                 32'h8000_0000, 32'h8000_0000}, 1'b0, '0});
    rows.insert(rows.size(), '{'{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                                 32'h7fff_ffff, 32'h8000_0000}, 1'b0, '0});
    rows.insert(rows.size(), '{'{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                                 32'h8000_0000, 32'h7fff_ffff}, 1'b0, '0});
    rows.insert(rows.size(), '{'{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                 32'h7fff_ffff, 32'h7fff_ffff}, 1'b0, '0});
    rows.insert(rows.size(),
                '{'{32'hffff_ffff, 0, 32'h8000_0000, 0, 32'hffff_ffff}, 1'b0, '0});
    rows.insert(rows.size(), '{'{1, 32'h7fff_ffff, 0, 32'h7fff_ffff, 0}, 1'b0, '0});
    // Tiny uv deltas over large edges.
    rows.insert(rows.size(), '{'{0, 0, 0, 0, 0}, 1'b0, '0});
    rows.insert(rows.size(), '{'{32'h4000_0000, 32'hc000_0000, 7, 1, 0}, 1'b0, '0});
    rows.insert(rows.size(), '{'{32'h8000_0001, 3, 32'h7fff_0000, 0, 1}, 1'b0, '0});

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i]) begin
      row = rows[i];
      send_vertex(row.vtx, row.typed, row.want);
    end

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = sidle[ph];
      recv_stall_pct = rstall[ph];
      // Long receiver hold-off so the block fills and stalls its input.
      if (ph == 0) hold_seq++;
      repeat (33) send_triangle();
      // Pause until every expected tangent has come back.
      @(negedge clk_i);
      push <= 1'b0;
      while (tangent_q.size() != 0) @(posedge clk_i);
    end

    @(negedge clk_i);
    push <= 1'b0;
    while (tangent_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
design/ttv_pkg.sv
design/ttv_front.sv
design/ttv_back.sv
design/triangle_tangent_vector.sv
design/ttv_checker.sv
dv/triangle_tangent_vector_tb.sv
